>>> src/ebs_pkg.sv
// ----------------------------------------------------------------------------
// ebs_pkg
// Shared types and constants for the event bitmap slicer: field widths,
// predicate layout, register indexes and the result stage phases.
// ----------------------------------------------------------------------------
package ebs_pkg;

   // Default sizing of the slicer
   localparam int DEF_NUM_TYPES = 4;
   localparam int DEF_WORD_BITS = 64;

   // Fixed field widths
   localparam int TS_W      = 32;
   localparam int TYPE_W    = 2;
   localparam int ATTR_W    = 24;
   localparam int WNUM_W    = 24;
   localparam int ANC_W     = 30;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 64;
   localparam int LEN_W     = 32;

   // Attributes carried by one event
   localparam int NUM_ATTRS  = 4;
   localparam int ATTR_IDX_W = $clog2(NUM_ATTRS);

   // Predicate registers: one per pattern type, two predicates each
   localparam int PRED_REGS    = 4;
   localparam int PRED_IDX_W   = $clog2(PRED_REGS);
   localparam int PRED_W       = 32;
   localparam int PRED_PER_REG = CSR_W / PRED_W;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE0_PRED   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE3_PRED   = 3'd4;

   // Comparison codes of one predicate (code 3 behaves as equal)
   localparam logic [1:0] OP_GT = 2'd0;
   localparam logic [1:0] OP_LT = 2'd1;
   localparam logic [1:0] OP_EQ = 2'd2;

   // Layout of one packed predicate
   typedef struct packed {
      logic              enable;
      logic [1:0]        op;
      logic [1:0]        attr_sel;
      logic [2:0]        spare;
      logic [ATTR_W-1:0] threshold;
   } pred_type;

   // Attribute vector handed to the predicate evaluator
   typedef logic [NUM_ATTRS-1:0][ATTR_W-1:0] attr_vec_type;

   // Phases of the result stage
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_UPDATE,
      PH_WORDS,
      PH_ANCHOR
   } phase_type;

endpackage

>>> src/ebs_pred_eval.sv
// ----------------------------------------------------------------------------
// ebs_pred_eval
// Evaluates the two packed predicates of one type register against the
// attributes of an event; passes when every enabled predicate holds.
// ----------------------------------------------------------------------------
module ebs_pred_eval
   import ebs_pkg::*;
(
   input  logic [CSR_W-1:0] pred_word,
   input  attr_vec_type     attrs,
   output logic             pred_pass
);

   // Check both predicates side by side
   always_comb begin
      pred_type                 pred;
      logic signed [ATTR_W-1:0] value;
      logic signed [ATTR_W-1:0] thresh;
      logic                     holds;
      pred_pass = 1'b1;
      for (int h = 0; h < PRED_PER_REG; h++) begin
         pred   = pred_type'(pred_word[h*PRED_W +: PRED_W]);
         value  = $signed(attrs[ATTR_IDX_W'(pred.attr_sel % NUM_ATTRS)]);
         thresh = $signed(pred.threshold);
         case (pred.op)
            OP_GT:   holds = (value > thresh);
            OP_LT:   holds = (value < thresh);
            OP_EQ:   holds = (value == thresh);
            default: holds = (value == thresh);
         endcase
         if (pred.enable && !holds) begin
            pred_pass = 1'b0;
         end
      end
   end

endmodule

>>> src/event_bitmap_slicer.sv
// ----------------------------------------------------------------------------
// event_bitmap_slicer
// Slices a timestamped event stream into per-type bitmap words, one bit per
// time slice, and reports anchor events with their absolute position.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one event (or a flush when req_func is set) per transaction
//   under valid/ready. rsp_* returns bitmap words and anchor records, one per
//   transaction; rsp_last marks the final result of an input transaction.
//   csr_we writes register csr_index (0 slice length, 1..4 type predicates).
// Timing:
//   An anchor record goes from the held transaction into the result register
//   once that register is free. Events without a word burst follow back to
//   back while any anchor record can be handed over. A word burst (full word
//   or flush) sends one word per type, then any anchor record, one word per
//   cycle while the result register is free. The type word memory has a
//   registered read port; a write to the entry being read is forwarded.
// Reset: clears slice start, bit position and word counter, marks every type
//   word empty, sets slice length to 1 and predicates to 0.
// Stall: the result register holds until rsp_ready; req_ready drops while a
//   word burst is in progress and while the result stage has a result it
//   cannot hand over.
// ----------------------------------------------------------------------------
module event_bitmap_slicer
   import ebs_pkg::*;
#(
   parameter int NUM_TYPES = DEF_NUM_TYPES,
   parameter int WORD_BITS = DEF_WORD_BITS
)
(
   input  logic                        clock,
   input  logic                        reset,
   // event channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_func,
   input  logic [TS_W-1:0]             req_timestamp,
   input  logic                        req_type_known,
   input  logic [TYPE_W-1:0]           req_type_index,
   input  logic signed [ATTR_W-1:0]    req_attr_a,
   input  logic signed [ATTR_W-1:0]    req_attr_b,
   input  logic signed [ATTR_W-1:0]    req_attr_c,
   input  logic signed [ATTR_W-1:0]    req_attr_d,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_kind,
   output logic [TYPE_W-1:0]           rsp_word_type,
   output logic [WNUM_W-1:0]           rsp_word_number,
   output logic [WORD_BITS-1:0]        rsp_bitmap_word,
   output logic [ANC_W-1:0]            rsp_anchor_position,
   output logic [TS_W-1:0]             rsp_anchor_time,
   output logic                        rsp_last,
   // configuration
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]            csr_wdata
);

   localparam int POS_W  = $clog2(WORD_BITS);
   localparam int TIDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam logic [TIDX_W-1:0] LAST_TYPE = TIDX_W'(NUM_TYPES - 1);
   localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(WORD_BITS - 1);

   // Configuration registers
   logic [LEN_W-1:0] len_ff;
   logic [CSR_W-1:0] pred_ff [PRED_REGS];

   // Slice tracking
   logic [TS_W-1:0]   ss_ff, ss_in;
   logic [POS_W-1:0]  bp_ff, bp_in;
   logic [WNUM_W-1:0] wc_ff, wc_in;

   // Result stage
   phase_type         phase_ff, phase_in;
   logic [TIDX_W-1:0] step_ff, step_in;
   logic              s1_set_ff;
   logic              s1_anchor_ff;
   logic [TIDX_W-1:0] s1_type_ff;
   logic [POS_W-1:0]  s1_pos_ff;
   logic [WNUM_W-1:0] s1_wnum_ff;
   logic [WNUM_W-1:0] s1_awc_ff;
   logic [TS_W-1:0]   s1_ts_ff;

   // Type word memory and its read port
   logic [WORD_BITS-1:0] mem_ram [NUM_TYPES];
   logic [WORD_BITS-1:0] mem_rdata_ff;
   logic [TIDX_W-1:0]    mem_raddr, mem_raddr_ff;
   logic                 mem_we;
   logic [TIDX_W-1:0]    mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic                 byp_ff;
   logic [WORD_BITS-1:0] byp_data_ff;
   logic [NUM_TYPES-1:0] valid_ff, valid_in;
   logic                 clear_all;
   logic [WORD_BITS-1:0] rd_word;

   // Result register
   logic                 rsp_valid_ff;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic [TYPE_W-1:0]    rsp_wtype_ff, rsp_wtype_in;
   logic [WNUM_W-1:0]    rsp_wnum_ff, rsp_wnum_in;
   logic [WORD_BITS-1:0] rsp_word_ff, rsp_word_in;
   logic [ANC_W-1:0]     rsp_apos_ff, rsp_apos_in;
   logic [TS_W-1:0]      rsp_atime_ff, rsp_atime_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Accept side
   logic                 in_acc;
   logic [TS_W:0]        slice_end;
   logic                 ts_adv;
   logic                 acc_burst;
   logic                 acc_set;
   logic                 acc_anchor;
   logic                 type_ok;
   logic                 pred_pass;
   attr_vec_type         attr_vec;
   logic [TIDX_W-1:0]    acc_type;

   // Stage control
   logic                 out_ok;
   logic                 fire;
   logic                 s1_done;
   logic                 out_load;
   logic                 step_adv;
   logic                 last_step;
   logic [WORD_BITS-1:0] bit_mask;
   logic [ANC_W-1:0]     anc_pos;

   // ------------------------------------------------------------------------
   // Configuration writes
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_W'(1);
         for (int i = 0; i < PRED_REGS; i++) begin
            pred_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == CSR_SLICE_LENGTH) begin
            len_ff <= csr_wdata[LEN_W-1:0];
         end else if (csr_index inside {[CSR_TYPE0_PRED:CSR_TYPE3_PRED]}) begin
            pred_ff[PRED_IDX_W'(csr_index - CSR_TYPE0_PRED)] <= csr_wdata;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Predicate check of the incoming event
   // ------------------------------------------------------------------------
   assign attr_vec[0] = req_attr_a;
   assign attr_vec[1] = req_attr_b;
   assign attr_vec[2] = req_attr_c;
   assign attr_vec[3] = req_attr_d;

   ebs_pred_eval u_pred_eval (
      .pred_word (pred_ff[PRED_IDX_W'(req_type_index)]),
      .attrs     (attr_vec),
      .pred_pass (pred_pass)
   );

   assign type_ok    = (int'(req_type_index) < NUM_TYPES);
   assign acc_set    = !req_func && req_type_known && type_ok && pred_pass;
   assign acc_anchor = acc_set && (req_type_index == '0);
   assign acc_type   = acc_set ? TIDX_W'(req_type_index) : '0;

   // ------------------------------------------------------------------------
   // Slice advance on each accepted transaction
   // ------------------------------------------------------------------------
   assign in_acc    = req_valid && req_ready;
   assign slice_end = {1'b0, ss_ff} + {1'b0, len_ff};
   assign ts_adv    = ({1'b0, req_timestamp} >= slice_end);
   assign acc_burst = req_func || (ts_adv && (bp_ff == LAST_POS));

   always_comb begin
      ss_in = ss_ff;
      bp_in = bp_ff;
      wc_in = wc_ff;
      if (req_func) begin
         bp_in = '0;
         wc_in = wc_ff + WNUM_W'(1);
      end else if (ts_adv) begin
         if (bp_ff == LAST_POS) begin
            bp_in = '0;
            wc_in = wc_ff + WNUM_W'(1);
            ss_in = req_timestamp;
         end else begin
            bp_in = bp_ff + POS_W'(1);
            ss_in = ss_ff + len_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ss_ff <= '0;
         bp_ff <= '0;
         wc_ff <= '0;
      end else if (in_acc) begin
         ss_ff <= ss_in;
         bp_ff <= bp_in;
         wc_ff <= wc_in;
      end
   end

   // Hold the transaction for the result stage
   always_ff @(posedge clock) begin
      if (in_acc) begin
         s1_set_ff    <= acc_set;
         s1_anchor_ff <= acc_anchor;
         s1_type_ff   <= acc_type;
         s1_pos_ff    <= bp_in;
         s1_wnum_ff   <= wc_ff;
         s1_awc_ff    <= wc_in;
         s1_ts_ff     <= req_timestamp;
      end
   end

   // ------------------------------------------------------------------------
   // Type word memory: registered read, forward a same-entry write
   // ------------------------------------------------------------------------
   always_comb begin
      if (in_acc) begin
         mem_raddr = acc_burst ? '0 : acc_type;
      end else if (step_adv) begin
         mem_raddr = step_ff + TIDX_W'(1);
      end else if (phase_ff == PH_WORDS) begin
         mem_raddr = step_ff;
      end else begin
         mem_raddr = s1_type_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem_ram[mem_raddr];
      mem_raddr_ff <= mem_raddr;
      byp_data_ff  <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff   <= 1'b0;
         valid_ff <= '0;
      end else begin
         byp_ff   <= mem_we && (mem_waddr == mem_raddr);
         valid_ff <= valid_in;
      end
   end

   // Drop all words on a burst, mark an entry once written
   always_comb begin
      valid_in = valid_ff;
      if (clear_all) begin
         valid_in = '0;
      end
      if (mem_we) begin
         valid_in[mem_waddr] = 1'b1;
      end
   end

   assign rd_word = byp_ff ? byp_data_ff :
                    (valid_ff[mem_raddr_ff] ? mem_rdata_ff : '0);

   assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << (LAST_POS - s1_pos_ff);
   assign anc_pos  = ANC_W'(ANC_W'(s1_awc_ff) * ANC_W'(WORD_BITS)) + ANC_W'(s1_pos_ff);

   // ------------------------------------------------------------------------
   // Result stage: next phase
   // ------------------------------------------------------------------------
   always_comb begin
      phase_in = phase_ff;
      if (in_acc) begin
         phase_in = acc_burst ? PH_WORDS : PH_UPDATE;
      end else if (s1_done) begin
         phase_in = PH_IDLE;
      end else if (phase_ff == PH_WORDS && fire && last_step) begin
         phase_in = PH_ANCHOR;
      end
   end

   always_comb begin
      step_in = step_ff;
      if (in_acc) begin
         step_in = '0;
      end else if (step_adv) begin
         step_in = step_ff + TIDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         step_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

   // ------------------------------------------------------------------------
   // Result stage: outputs, memory writes and result fields
   // ------------------------------------------------------------------------
   assign out_ok    = !rsp_valid_ff || rsp_ready;
   assign last_step = (step_ff == LAST_TYPE);
   assign req_ready = (phase_ff == PH_IDLE) || s1_done;

   always_comb begin
      fire         = 1'b0;
      s1_done      = 1'b0;
      out_load     = 1'b0;
      step_adv     = 1'b0;
      clear_all    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = s1_type_ff;
      mem_wdata    = rd_word | bit_mask;
      rsp_kind_in  = 1'b1;
      rsp_wtype_in = '0;
      rsp_wnum_in  = '0;
      rsp_word_in  = '0;
      rsp_apos_in  = anc_pos;
      rsp_atime_in = s1_ts_ff;
      rsp_last_in  = 1'b1;
      case (phase_ff)
         PH_UPDATE: begin
            fire     = s1_anchor_ff ? out_ok : 1'b1;
            s1_done  = fire;
            out_load = fire && s1_anchor_ff;
            mem_we   = fire && s1_set_ff;
         end
         PH_WORDS: begin
            fire         = out_ok;
            out_load     = fire;
            step_adv     = fire && !last_step;
            s1_done      = fire && last_step && !s1_anchor_ff;
            clear_all    = fire && last_step;
            mem_we       = fire && last_step && s1_set_ff;
            mem_wdata    = bit_mask;
            rsp_kind_in  = 1'b0;
            rsp_wtype_in = TYPE_W'(step_ff);
            rsp_wnum_in  = s1_wnum_ff;
            rsp_word_in  = rd_word;
            rsp_apos_in  = '0;
            rsp_atime_in = '0;
            rsp_last_in  = last_step && !s1_anchor_ff;
         end
         PH_ANCHOR: begin
            fire     = out_ok;
            out_load = fire;
            s1_done  = fire;
         end
         default: begin
            fire = 1'b0;
         end
      endcase
   end

   // Result register parts the two channels
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_wtype_ff <= rsp_wtype_in;
         rsp_wnum_ff  <= rsp_wnum_in;
         rsp_word_ff  <= rsp_word_in;
         rsp_apos_ff  <= rsp_apos_in;
         rsp_atime_ff <= rsp_atime_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_word_type       = rsp_wtype_ff;
   assign rsp_word_number     = rsp_wnum_ff;
   assign rsp_bitmap_word     = rsp_word_ff;
   assign rsp_anchor_position = rsp_apos_ff;
   assign rsp_anchor_time     = rsp_atime_ff;
   assign rsp_last            = rsp_last_ff;

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for event_bitmap_slicer. A scripted opening pass walks
// register extremes, every comparison code and the slice boundary cases; then
// randomized phases stream events and flushes under random sender gaps and
// receiver stalls. Every result transaction is checked field by field
// against an in-bench model of the slicer state or a scripted anchor record.
// ----------------------------------------------------------------------------
module testbench;
   import ebs_pkg::*;

   localparam int NTYPES         = DEF_NUM_TYPES;
   localparam int WBITS          = DEF_WORD_BITS;
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic FUNC_EVENT  = 1'b0;
   localparam logic FUNC_FLUSH  = 1'b1;
   localparam logic KIND_WORD   = 1'b0;
   localparam logic KIND_ANCHOR = 1'b1;

   // Spare comparison code, behaves as equal
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam logic [ATTR_W-1:0] ATTR_MAX = {1'b0, {(ATTR_W-1){1'b1}}};
   localparam logic [ATTR_W-1:0] ATTR_MIN = {1'b1, {(ATTR_W-1){1'b0}}};

   typedef struct packed {
      logic              func;
      logic [TS_W-1:0]   timestamp;
      logic              known;
      logic [TYPE_W-1:0] type_index;
      attr_vec_type      attrs;
   } event_item_type;

   typedef struct packed {
      logic              kind;
      logic [TYPE_W-1:0] word_type;
      logic [WNUM_W-1:0] word_number;
      logic [WBITS-1:0]  bitmap_word;
      logic [ANC_W-1:0]  anchor_position;
      logic [TS_W-1:0]   anchor_time;
      logic              last;
   } slice_result_type;

   typedef struct packed {
      logic             typed;
      slice_result_type rec;
   } typed_note_type;

   typedef enum logic [1:0] {
      ROW_EVENT,
      ROW_REG
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] reg_index;
      logic [CSR_W-1:0]     reg_value;
      event_item_type       ev;
      logic                 typed;
      slice_result_type     want;
   } script_row_type;

   // DUT connections, all inputs known from time zero
   logic                     clock           = 1'b0;
   logic                     reset           = 1'b1;
   logic                     req_valid       = 1'b0;
   logic                     req_ready;
   logic                     req_func        = 1'b0;
   logic [TS_W-1:0]          req_timestamp   = '0;
   logic                     req_type_known  = 1'b0;
   logic [TYPE_W-1:0]        req_type_index  = '0;
   logic signed [ATTR_W-1:0] req_attr_a      = '0;
   logic signed [ATTR_W-1:0] req_attr_b      = '0;
   logic signed [ATTR_W-1:0] req_attr_c      = '0;
   logic signed [ATTR_W-1:0] req_attr_d      = '0;
   logic                     rsp_valid;
   logic                     rsp_ready       = 1'b0;
   logic                     rsp_kind;
   logic [TYPE_W-1:0]        rsp_word_type;
   logic [WNUM_W-1:0]        rsp_word_number;
   logic [WBITS-1:0]         rsp_bitmap_word;
   logic [ANC_W-1:0]         rsp_anchor_position;
   logic [TS_W-1:0]          rsp_anchor_time;
   logic                     rsp_last;
   logic                     csr_we          = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index       = '0;
   logic [CSR_W-1:0]         csr_wdata       = '0;

   // Slicer model state and registers
   logic [TS_W-1:0]   m_start  = '0;
   logic [5:0]        m_pos    = '0;
   logic [WNUM_W-1:0] m_wcount = '0;
   logic [WBITS-1:0]  m_words [NTYPES];
   logic [LEN_W-1:0]  m_len    = 1;
   logic [CSR_W-1:0]  m_preds [PRED_REGS];

   slice_result_type step_results[$];
   slice_result_type pending_results[$];
   typed_note_type   typed_notes[$];
   script_row_type   script[$];

   int              mismatches     = 0;
   int              stalled_cycles = 0;
   int              ready_left     = 0;
   bit              calm           = 1'b0;
   logic [TS_W-1:0] cur_ts         = 32'd1000;
   logic [LEN_W-1:0] phase_len     = 1;

   initial begin
      foreach (m_words[t]) m_words[t] = '0;
      foreach (m_preds[t]) m_preds[t] = '0;
   end

   event_bitmap_slicer uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_timestamp       (req_timestamp),
      .req_type_known      (req_type_known),
      .req_type_index      (req_type_index),
      .req_attr_a          (req_attr_a),
      .req_attr_b          (req_attr_b),
      .req_attr_c          (req_attr_c),
      .req_attr_d          (req_attr_d),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_word_type       (rsp_word_type),
      .rsp_word_number     (rsp_word_number),
      .rsp_bitmap_word     (rsp_bitmap_word),
      .rsp_anchor_position (rsp_anchor_position),
      .rsp_anchor_time     (rsp_anchor_time),
      .rsp_last            (rsp_last),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- model

   // Apply a register write to the model copy
   function automatic void load_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      if (idx == CSR_SLICE_LENGTH)
         m_len = val[LEN_W-1:0];
      else if (idx inside {[CSR_TYPE0_PRED:CSR_TYPE3_PRED]})
         m_preds[PRED_IDX_W'(idx - CSR_TYPE0_PRED)] = val;
   endfunction

   // Emit every type word with the current word number, then clear them
   function automatic void emit_words();
      slice_result_type r;
      for (int t = 0; t < NTYPES; t++) begin
         r = '0;
         r.kind        = KIND_WORD;
         r.word_type   = TYPE_W'(t);
         r.word_number = m_wcount;
         r.bitmap_word = m_words[t];
         step_results = {step_results, r};
         m_words[t] = '0;
      end
      m_wcount = m_wcount + 1'b1;
      m_pos    = '0;
   endfunction

   // All enabled predicates of a type must hold; the 2-bit selector spans all attributes
   function automatic bit predicates_hold(logic [TYPE_W-1:0] ty, attr_vec_type at);
      pred_type                 pr;
      logic signed [ATTR_W-1:0] v;
      logic signed [ATTR_W-1:0] thr;
      for (int h = 0; h < PRED_PER_REG; h++) begin
         pr = m_preds[ty][h*PRED_W +: PRED_W];
         if (!pr.enable) continue;
         v   = at[pr.attr_sel];
         thr = pr.threshold;
         case (pr.op)
            OP_GT:   if (!(v > thr)) return 1'b0;
            OP_LT:   if (!(v < thr)) return 1'b0;
            default: if (v != thr) return 1'b0;
         endcase
      end
      return 1'b1;
   endfunction

   // Work out the results of one input transaction into step_results
   function automatic void slice_event(event_item_type ev);
      slice_result_type r;
      logic [ANC_W-1:0] ap;
      step_results.delete();
      if (ev.func == FUNC_FLUSH) begin
         emit_words();
      end else begin
         // boundary compare is one bit wider than the timestamp
         if ({1'b0, ev.timestamp} >= {1'b0, m_start} + {1'b0, m_len}) begin
            if (m_pos >= WBITS - 1) begin
               emit_words();
               m_start = ev.timestamp;
            end else begin
               m_pos   = m_pos + 1'b1;
               m_start = m_start + m_len;
            end
         end
         if (ev.known && ev.type_index < NTYPES && predicates_hold(ev.type_index, ev.attrs)) begin
            m_words[ev.type_index][WBITS-1-m_pos] = 1'b1;
            if (ev.type_index == 0) begin
               ap = ANC_W'(m_wcount * WBITS + m_pos);
               r = '0;
               r.kind            = KIND_ANCHOR;
               r.anchor_position = ap;
               r.anchor_time     = ev.timestamp;
               step_results = {step_results, r};
            end
         end
      end
      if (step_results.size() > 0)
         step_results[step_results.size()-1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h, want %h", what, got, want);
      mismatches++;
   endtask

   // Sample both channels at the edge; predict on requests, check on results
   always @(posedge clock) begin : monitor
      event_item_type   ev;
      slice_result_type got;
      slice_result_type want;
      typed_note_type   note;
      if (!reset) begin
         if (csr_we) load_register(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            ev.func       = req_func;
            ev.timestamp  = req_timestamp;
            ev.known      = req_type_known;
            ev.type_index = req_type_index;
            ev.attrs[0]   = req_attr_a;
            ev.attrs[1]   = req_attr_b;
            ev.attrs[2]   = req_attr_c;
            ev.attrs[3]   = req_attr_d;
            note = typed_notes.pop_front();
            slice_event(ev);
            if (note.typed)
               pending_results = {pending_results, note.rec};
            else
               pending_results = {pending_results, step_results};
         end
         if (rsp_valid && rsp_ready) begin
            got.kind            = rsp_kind;
            got.word_type       = rsp_word_type;
            got.word_number     = rsp_word_number;
            got.bitmap_word     = rsp_bitmap_word;
            got.anchor_position = rsp_anchor_position;
            got.anchor_time     = rsp_anchor_time;
            got.last            = rsp_last;
            if (pending_results.size() == 0) begin
               flag_mismatch("unexpected result", got.bitmap_word, '0);
            end else begin
               want = pending_results.pop_front();
               if (got.kind !== want.kind)
                  flag_mismatch("kind", 64'(got.kind), 64'(want.kind));
               if (got.word_type !== want.word_type)
                  flag_mismatch("word_type", 64'(got.word_type), 64'(want.word_type));
               if (got.word_number !== want.word_number)
                  flag_mismatch("word_number", 64'(got.word_number),
                                64'(want.word_number));
               if (got.bitmap_word !== want.bitmap_word)
                  flag_mismatch("bitmap_word", got.bitmap_word, want.bitmap_word);
               if (got.anchor_position !== want.anchor_position)
                  flag_mismatch("anchor_position", 64'(got.anchor_position),
                                64'(want.anchor_position));
               if (got.anchor_time !== want.anchor_time)
                  flag_mismatch("anchor_time", 64'(got.anchor_time),
                                64'(want.anchor_time));
               if (got.last !== want.last)
                  flag_mismatch("last", 64'(got.last), 64'(want.last));
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         stalled_cycles = 0;
      else
         stalled_cycles = stalled_cycles + 1;
   end

   // Stop a hung run
   initial begin
      while (stalled_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("testbench: errors");
      $finish;
   end

   // Receiver: random ready and stall bursts, none once calm
   always @(posedge clock) begin
      if (calm) begin
         rsp_ready  <= 1'b1;
         ready_left = 0;
      end else if (ready_left == 0) begin
         rsp_ready  <= ($urandom_range(0, 2) != 0);
         ready_left = $urandom_range(1, 13);
      end else begin
         ready_left = ready_left - 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic event_item_type mk_ev(logic f, logic [TS_W-1:0] ts, logic known,
                                            logic [TYPE_W-1:0] ty, logic [ATTR_W-1:0] a,
                                            logic [ATTR_W-1:0] b, logic [ATTR_W-1:0] c,
                                            logic [ATTR_W-1:0] d);
      event_item_type ev;
      ev.func       = f;
      ev.timestamp  = ts;
      ev.known      = known;
      ev.type_index = ty;
      ev.attrs[0]   = a;
      ev.attrs[1]   = b;
      ev.attrs[2]   = c;
      ev.attrs[3]   = d;
      return ev;
   endfunction

   function automatic logic [PRED_W-1:0] mk_pred(logic en, logic [1:0] op, logic [1:0] sel,
                                                 logic [ATTR_W-1:0] thr);
      pred_type pr;
      pr.enable    = en;
      pr.op        = op;
      pr.attr_sel  = sel;
      pr.spare     = '0;
      pr.threshold = thr;
      return pr;
   endfunction

   function automatic void add_event(event_item_type ev);
      script_row_type r;
      r = '0;
      r.kind = ROW_EVENT;
      r.ev   = ev;
      script = {script, r};
   endfunction

   // Event row whose single anchor record is written out directly
   function automatic void add_anchor(event_item_type ev, logic [ANC_W-1:0] pos);
      script_row_type r;
      r = '0;
      r.kind                 = ROW_EVENT;
      r.ev                   = ev;
      r.typed                = 1'b1;
      r.want.kind            = KIND_ANCHOR;
      r.want.anchor_position = pos;
      r.want.anchor_time     = ev.timestamp;
      r.want.last            = 1'b1;
      script = {script, r};
   endfunction

   function automatic void add_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      script_row_type r;
      r = '0;
      r.kind      = ROW_REG;
      r.reg_index = idx;
      r.reg_value = val;
      script = {script, r};
   endfunction

   function automatic void build_script();
      // reset defaults: unit slices, no predicates
      add_anchor(mk_ev(FUNC_EVENT, 32'h0, 1, 0, 0, 0, 0, 0), 0);
      add_anchor(mk_ev(FUNC_EVENT, '1, 1, 0, ATTR_MAX, ATTR_MAX, ATTR_MAX, ATTR_MAX), 1);
      add_event(mk_ev(FUNC_EVENT, '1, 0, 0, 0, 0, 0, 0));
      add_event(mk_ev(FUNC_EVENT, 32'h2, 1, 3, ATTR_MIN, ATTR_MIN, ATTR_MIN, ATTR_MIN));
      add_event(mk_ev(FUNC_FLUSH, '1, 1, 3, ATTR_MAX, ATTR_MAX, ATTR_MAX, ATTR_MAX));
      // widest slice and one predicate pair per comparison code
      add_reg(CSR_SLICE_LENGTH, 64'hFFFF_FFFF);
      add_reg(CSR_TYPE0_PRED, {mk_pred(1, OP_LT, 1, -5), mk_pred(1, OP_GT, 0, 100)});
      add_reg(CSR_TYPE0_PRED + CSR_IDX_W'(1),
              {mk_pred(1, OP_SPARE, 3, ATTR_MIN), mk_pred(1, OP_EQ, 2, ATTR_MAX)});
      add_reg(CSR_TYPE0_PRED + CSR_IDX_W'(2),
              {mk_pred(0, OP_LT, 1, 5), mk_pred(0, OP_GT, 2, 5)});
      add_reg(CSR_TYPE3_PRED, {mk_pred(1, OP_LT, 0, ATTR_MAX), mk_pred(1, OP_GT, 3, ATTR_MIN)});
      add_anchor(mk_ev(FUNC_EVENT, 32'h1234_5678, 1, 0, 101, -6, 0, 0), 64);
      add_event(mk_ev(FUNC_EVENT, 32'h10, 1, 0, 100, -6, 0, 0));
      add_event(mk_ev(FUNC_EVENT, 32'h10, 1, 0, 101, -5, 0, 0));
      add_event(mk_ev(FUNC_EVENT, 32'h11, 1, 1, 0, 0, ATTR_MAX, ATTR_MIN));
      add_event(mk_ev(FUNC_EVENT, 32'h11, 1, 1, 0, 0, ATTR_MAX, 0));
      add_event(mk_ev(FUNC_EVENT, 32'h12, 1, 1, 0, 0, ATTR_MAX - 1, ATTR_MIN));
      add_event(mk_ev(FUNC_EVENT, 32'h12, 1, 2, ATTR_MIN, 7, -1, ATTR_MAX));
      add_event(mk_ev(FUNC_EVENT, 32'h13, 1, 3, 0, 0, 0, ATTR_MIN));
      add_event(mk_ev(FUNC_EVENT, 32'h13, 1, 3, ATTR_MAX, 0, 0, 0));
      add_event(mk_ev(FUNC_EVENT, 32'h14, 1, 3, 0, 0, 0, 0));
      // slice end past the 32-bit range: no advance
      add_anchor(mk_ev(FUNC_EVENT, '1, 1, 0, 101, -6, 0, 0), 64);
      add_event(mk_ev(FUNC_FLUSH, 32'h0, 0, 0, 0, 0, 0, 0));
      // zero slice length, timestamps behind the slice start, repeated anchors
      add_reg(CSR_SLICE_LENGTH, 64'h0);
      add_reg(CSR_TYPE0_PRED, 64'h0);
      add_anchor(mk_ev(FUNC_EVENT, 32'h0, 1, 0, 0, 0, 0, 0), 128);
      add_anchor(mk_ev(FUNC_EVENT, 32'h2, 1, 0, 0, 0, 0, 0), 129);
      add_anchor(mk_ev(FUNC_EVENT, 32'h1, 1, 0, 0, 0, 0, 0), 129);
      // large gap advances by one slice only
      add_reg(CSR_SLICE_LENGTH, 64'd5);
      add_anchor(mk_ev(FUNC_EVENT, 32'd1000, 1, 0, 0, 0, 0, 0), 130);
      add_anchor(mk_ev(FUNC_EVENT, 32'd1000, 1, 0, 0, 0, 0, 0), 131);
      add_event(mk_ev(FUNC_FLUSH, 32'd1000, 1, 0, 0, 0, 0, 0));
   endfunction

   function automatic logic [ATTR_W-1:0] rand_attr();
      case ($urandom_range(0, 4))
         0, 1:    return ATTR_W'($urandom_range(0, 6) - 3);
         2:       return ATTR_MAX;
         3:       return ATTR_MIN;
         default: return ATTR_W'($urandom());
      endcase
   endfunction

   function automatic logic [PRED_W-1:0] rand_pred();
      pred_type pr;
      pr.enable   = ($urandom_range(0, 2) != 0);
      pr.op       = 2'($urandom_range(0, 3));
      pr.attr_sel = 2'($urandom_range(0, 3));
      pr.spare    = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
         0, 1:    pr.threshold = ATTR_W'($urandom_range(0, 4) - 2);
         2:       pr.threshold = $urandom_range(0, 1) ? ATTR_MAX : ATTR_MIN;
         default: pr.threshold = ATTR_W'($urandom());
      endcase
      return pr;
   endfunction

   function automatic logic [LEN_W-1:0] rand_len();
      case ($urandom_range(0, 4))
         0:       return 1;
         1:       return LEN_W'($urandom_range(2, 6));
         2:       return '1;
         3:       return $urandom();
         default: return 0;
      endcase
   endfunction

   // Mostly forward time near the slice length, with jumps and steps back
   function automatic event_item_type rand_event(bit allow_flush);
      event_item_type  ev;
      logic [TS_W-1:0] span;
      span = (phase_len < 16) ? TS_W'(2 * phase_len + 1) : phase_len;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: cur_ts = cur_ts + $urandom_range(0, span);
         6:                cur_ts = cur_ts - $urandom_range(0, 5);
         7:                cur_ts = $urandom();
         8:                cur_ts = '1;
         default:          ;
      endcase
      ev.func       = (allow_flush && $urandom_range(0, 9) == 0) ? FUNC_FLUSH : FUNC_EVENT;
      ev.timestamp  = cur_ts;
      ev.known      = ($urandom_range(0, 7) != 0);
      ev.type_index = TYPE_W'($urandom_range(0, 3));
      for (int i = 0; i < NUM_ATTRS; i++) ev.attrs[i] = rand_attr();
      return ev;
   endfunction

   // Present one transaction and hold it until accepted
   task automatic send_event(event_item_type ev, logic typed, slice_result_type want);
      typed_note_type note;
      note.typed = typed;
      note.rec   = want;
      typed_notes = {typed_notes, note};
      req_valid      <= 1'b1;
      req_func       <= ev.func;
      req_timestamp  <= ev.timestamp;
      req_type_known <= ev.known;
      req_type_index <= ev.type_index;
      req_attr_a     <= ev.attrs[0];
      req_attr_b     <= ev.attrs[1];
      req_attr_c     <= ev.attrs[2];
      req_attr_d     <= ev.attrs[3];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Random idle burst on the request side
   task automatic sender_gap();
      int n;
      if (!calm && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every expected result is in and the block settles
   task automatic drain_results();
      req_valid <= 1'b0;
      do begin
         while (pending_results.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end while (pending_results.size() != 0);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int n_items;
      build_script();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // scripted pass
      foreach (script[i]) begin
         if (script[i].kind == ROW_REG) begin
            write_reg(script[i].reg_index, script[i].reg_value);
         end else begin
            sender_gap();
            send_event(script[i].ev, script[i].typed, script[i].want);
         end
      end

      // random phases; the first one runs zero-length slices long enough to fill a word
      for (int p = 0; p < 5; p++) begin
         calm      = (p == 4);
         phase_len = (p == 0) ? '0 : rand_len();
         write_reg(CSR_SLICE_LENGTH, phase_len);
         for (int t = 0; t < PRED_REGS; t++)
            write_reg(CSR_TYPE0_PRED + CSR_IDX_W'(t), {rand_pred(), rand_pred()});
         n_items = (p == 0) ? 66 : 4;
         for (int k = 0; k < n_items; k++) begin
            // hold the sender until the block is empty once mid-phase
            if (p == 1 && k == 2) drain_results();
            sender_gap();
            send_event(rand_event(p != 0), 1'b0, '0);
         end
      end

      drain_results();
      if (mismatches == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
